[design/rrc_pkg.sv]
// ----------------------------------------------------------------------------
// rrc_pkg: shared types, constants and log table for range_remap_with_curve
// Holds the fixed-point formats, register indexes, item kinds and the
// interpolation table for the log10(1+9t) curve.
// ----------------------------------------------------------------------------
package rrc_pkg;

    // Fraction bits of the normalized ratio t; 1.0 is 2^T_FRAC_BITS.
    localparam int T_FRAC_BITS = 16;
    localparam int T_W         = T_FRAC_BITS + 1;
    // Log table segments (a power of two); the table holds one more point.
    localparam int LOG_TABLE_ENTRIES = 256;
    localparam int LOG_IDX_W         = $clog2(LOG_TABLE_ENTRIES);
    // Width of the Q16.16 sample, register and result words.
    localparam int Q_W = 32;
    // Fraction bits of the integer log2 used to build the table.
    localparam int LG_FRAC = 30;

    localparam logic [T_W-1:0] ONE_T = {1'b1, {T_FRAC_BITS{1'b0}}};

    // Queue between the front and back parts.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_IN_LOW       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IN_HIGH      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LOW      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_HIGH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CURVE_SELECT = 3'd4;

    // Curve codes; the unused code behaves as linear.
    localparam logic [1:0] CURVE_LIN  = 2'd0;
    localparam logic [1:0] CURVE_SQRT = 2'd1;
    localparam logic [1:0] CURVE_LOG  = 2'd2;

    // How an item is resolved after classification.
    typedef enum logic [1:0] {
        KIND_NAN,   // sample not finite, result is out_low
        KIND_MID,   // degenerate input range, result is the output midpoint
        KIND_T,     // ratio clamped to 0 or 1, carried in num bit 0
        KIND_DIV    // ratio strictly inside (0,1), needs the divider
    } kind_t;

    typedef struct packed {
        logic signed [Q_W-1:0] in_low;
        logic signed [Q_W-1:0] in_high;
        logic signed [Q_W-1:0] out_low;
        logic signed [Q_W-1:0] out_high;
        logic [1:0]            curve;
    } cfg_t;

    typedef struct packed {
        kind_t          kind;
        logic [Q_W-1:0] num;
        logic [Q_W-1:0] den;
    } job_t;

    typedef struct packed {
        kind_t          kind;
        logic [T_W-1:0] t;
    } tval_t;

    typedef logic [T_W-1:0] log_rom_t [0:LOG_TABLE_ENTRIES];

    // log2 of y (Q.LG_FRAC, y >= 1) by repeated squaring, result Q.LG_FRAC.
    function automatic logic [63:0] fix_log2(input logic [63:0] y_in);
        logic [63:0] y;
        logic [63:0] res;
        logic [63:0] two;
        int          k;
        int          b;
        y   = y_in;
        res = 64'd0;
        two = 64'd2 << LG_FRAC;
        for (k = 0; k < 64; k++)
        begin
            if (y >= two)
            begin
                y   = y >> 1;
                res = res + (64'd1 << LG_FRAC);
            end
        end
        for (b = LG_FRAC - 1; b >= 0; b--)
        begin
            y = (y * y) >> LG_FRAC;
            if (y >= two)
            begin
                y   = y >> 1;
                res = res | (64'd1 << b);
            end
        end
        return res;
    endfunction

    // log2(10) in Q.LG_FRAC, the divisor that turns log2 into log10.
    localparam logic [63:0] LOG2_TEN = fix_log2(64'd10 << LG_FRAC);

    // Entry i is round(2^T_FRAC_BITS * log10(1 + 9 i / LOG_TABLE_ENTRIES)).
    function automatic log_rom_t build_log_rom();
        log_rom_t    rom;
        logic [63:0] num;
        logic [63:0] y;
        logic [63:0] l;
        logic [63:0] q;
        int          i;
        for (i = 0; i <= LOG_TABLE_ENTRIES; i++)
        begin
            num    = 64'(LOG_TABLE_ENTRIES) + 64'd9 * 64'(i);
            y      = (num << LG_FRAC) >> LOG_IDX_W;
            l      = fix_log2(y);
            q      = ((l << T_FRAC_BITS) + (LOG2_TEN >> 1)) / LOG2_TEN;
            rom[i] = q[T_W-1:0];
        end
        return rom;
    endfunction

    localparam log_rom_t LOG_ROM = build_log_rom();

endpackage

[design/rrc_front.sv]
// ----------------------------------------------------------------------------
// rrc_front: input stage
// Accepts a sample beat, forms the signed ratio terms and classifies the
// item before it enters the queue.
// ----------------------------------------------------------------------------
module rrc_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [rrc_pkg::Q_W-1:0] sample,
    input  logic                          sample_finite,
    input  rrc_pkg::cfg_t                 cfg,
    output logic                          job_valid,
    output rrc_pkg::job_t                 job,
    input  logic                          job_full
);

    logic                    valid_reg;
    rrc_pkg::job_t           job_reg;
    rrc_pkg::job_t           job_next;
    logic signed [rrc_pkg::Q_W:0] num_s;
    logic signed [rrc_pkg::Q_W:0] den_s;
    logic signed [rrc_pkg::Q_W:0] num_a;
    logic signed [rrc_pkg::Q_W:0] den_a;
    logic                    load;

    assign in_stall  = valid_reg && job_full;
    assign load      = in_valid && !in_stall;
    assign job_valid = valid_reg;
    assign job       = job_reg;

    always_comb
    begin
        num_s = $signed({sample[rrc_pkg::Q_W-1], sample})
              - $signed({cfg.in_low[rrc_pkg::Q_W-1], cfg.in_low});
        den_s = $signed({cfg.in_high[rrc_pkg::Q_W-1], cfg.in_high})
              - $signed({cfg.in_low[rrc_pkg::Q_W-1], cfg.in_low});
        // A reversed range flips both signs so the divisor is positive.
        num_a = den_s[rrc_pkg::Q_W] ? -num_s : num_s;
        den_a = den_s[rrc_pkg::Q_W] ? -den_s : den_s;
        job_next.num = num_a[rrc_pkg::Q_W-1:0];
        job_next.den = den_a[rrc_pkg::Q_W-1:0];
        if (!sample_finite)
        begin
            job_next.kind = rrc_pkg::KIND_NAN;
        end
        else if (cfg.in_low == cfg.in_high)
        begin
            job_next.kind = rrc_pkg::KIND_MID;
        end
        else if (num_a[rrc_pkg::Q_W] || (num_a == '0))
        begin
            job_next.kind = rrc_pkg::KIND_T;
            job_next.num  = '0;
        end
        else if (num_a >= den_a)
        begin
            job_next.kind = rrc_pkg::KIND_T;
            job_next.num  = {{(rrc_pkg::Q_W-1){1'b0}}, 1'b1};
        end
        else
        begin
            job_next.kind = rrc_pkg::KIND_DIV;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_reg <= job_next;
        end
    end

endmodule

[design/rrc_fifo.sv]
// ----------------------------------------------------------------------------
// rrc_fifo: short queue between the front and back parts
// A small register queue with independent push and pop.
// ----------------------------------------------------------------------------
module rrc_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rrc_pkg::job_t push_data,
    output logic          full,
    input  logic          pop,
    output rrc_pkg::job_t pop_data,
    output logic          empty
);

    rrc_pkg::job_t                   mem_reg [0:rrc_pkg::FIFO_DEPTH-1];
    logic [rrc_pkg::FIFO_PTR_W-1:0]  wr_ptr_reg;
    logic [rrc_pkg::FIFO_PTR_W-1:0]  rd_ptr_reg;
    logic [rrc_pkg::FIFO_PTR_W:0]    count_reg;
    logic [rrc_pkg::FIFO_PTR_W:0]    count_next;
    logic                            do_push;
    logic                            do_pop;

    assign full     = (count_reg == (rrc_pkg::FIFO_PTR_W+1)'(rrc_pkg::FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[design/rrc_div.sv]
// ----------------------------------------------------------------------------
// rrc_div: pipelined ratio divider
// Restoring division, one quotient bit per stage, giving t = num * 2^F / den
// for items strictly inside the range; clamped items pass alongside.
// ----------------------------------------------------------------------------
module rrc_div (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  rrc_pkg::job_t in_job,
    output logic          out_valid,
    output rrc_pkg::tval_t out_item
);

    localparam int F = rrc_pkg::T_FRAC_BITS;
    localparam int W = rrc_pkg::Q_W;

    logic                v_reg    [0:F];
    rrc_pkg::kind_t      kind_reg [0:F];
    logic                one_reg  [0:F];
    logic [W:0]          r_reg    [0:F];
    logic [W-1:0]        den_reg  [0:F];
    logic [F-1:0]        q_reg    [0:F];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind_reg[0] <= in_job.kind;
            one_reg[0]  <= in_job.num[0];
            r_reg[0]    <= {1'b0, in_job.num};
            den_reg[0]  <= in_job.den;
            q_reg[0]    <= '0;
        end
    end

    for (genvar k = 1; k <= F; k++)
    begin : g_stage
        logic [W:0] r_sh;
        logic       ge;

        // The partial remainder stays below den, so the shift cannot overflow.
        assign r_sh = {r_reg[k-1][W-1:0], 1'b0};
        assign ge   = (r_sh >= {1'b0, den_reg[k-1]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                kind_reg[k] <= kind_reg[k-1];
                one_reg[k]  <= one_reg[k-1];
                den_reg[k]  <= den_reg[k-1];
                r_reg[k]    <= ge ? (r_sh - {1'b0, den_reg[k-1]}) : r_sh;
                q_reg[k]    <= {q_reg[k-1][F-2:0], ge};
            end
        end
    end

    assign out_valid     = v_reg[F];
    assign out_item.kind = kind_reg[F];
    assign out_item.t    = (kind_reg[F] == rrc_pkg::KIND_DIV) ? {1'b0, q_reg[F]}
                         : (one_reg[F] ? rrc_pkg::ONE_T : '0);

endmodule

[design/rrc_sqrt.sv]
// ----------------------------------------------------------------------------
// rrc_sqrt: pipelined square root
// Digit-by-digit integer square root of t * 2^F, one root bit per stage,
// with the item carried alongside for the later curve selection.
// ----------------------------------------------------------------------------
module rrc_sqrt (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  rrc_pkg::tval_t in_item,
    output logic           out_valid,
    output rrc_pkg::tval_t out_item,
    output logic [rrc_pkg::T_W-1:0] root
);

    localparam int F = rrc_pkg::T_FRAC_BITS;
    localparam int X_W = 2 * F + 1;

    logic           v_reg    [0:F];
    rrc_pkg::tval_t item_reg [0:F];
    logic [X_W-1:0] x_reg    [0:F];
    logic [X_W-1:0] res_reg  [0:F];

    for (genvar k = 0; k <= F; k++)
    begin : g_stage
        localparam logic [X_W-1:0] BIT = X_W'(1) << (2 * (F - k));
        logic           v_in;
        rrc_pkg::tval_t item_in;
        logic [X_W-1:0] x_in;
        logic [X_W-1:0] res_in;
        logic [X_W-1:0] trial;
        logic           take;

        if (k == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign item_in = in_item;
            assign x_in    = {in_item.t, {F{1'b0}}};
            assign res_in  = '0;
        end
        else
        begin : g_rest
            assign v_in    = v_reg[k-1];
            assign item_in = item_reg[k-1];
            assign x_in    = x_reg[k-1];
            assign res_in  = res_reg[k-1];
        end

        assign trial = res_in + BIT;
        assign take  = (x_in >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                item_reg[k] <= item_in;
                x_reg[k]    <= take ? (x_in - trial) : x_in;
                res_reg[k]  <= take ? ((res_in >> 1) + BIT) : (res_in >> 1);
            end
        end
    end

    assign out_valid = v_reg[F];
    assign out_item  = item_reg[F];
    assign root      = res_reg[F][rrc_pkg::T_W-1:0];

endmodule

[design/rrc_back.sv]
// ----------------------------------------------------------------------------
// rrc_back: curve shaping, output mapping and output register
// Reads the log table, selects the shaped ratio, scales it into the output
// range and holds the result beat until it is taken.
// ----------------------------------------------------------------------------
module rrc_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rrc_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    input  rrc_pkg::tval_t                in_item,
    input  logic [rrc_pkg::T_W-1:0]       in_root,
    output logic                          advance,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [rrc_pkg::Q_W-1:0] mapped
);

    localparam int F  = rrc_pkg::T_FRAC_BITS;
    localparam int TW = rrc_pkg::T_W;
    localparam int IW = rrc_pkg::LOG_IDX_W;
    localparam int W  = rrc_pkg::Q_W;
    localparam int P_W = TW + 1 + W + 1;

    // Stage A: table read.
    logic            a_v_reg;
    rrc_pkg::kind_t  a_kind_reg;
    logic [TW-1:0]   a_t_reg;
    logic [TW-1:0]   a_root_reg;
    logic [TW-1:0]   a_lo_reg;
    logic [TW-1:0]   a_diff_reg;
    logic [F-1:0]    a_frac_reg;
    // Stage B: shaped ratio.
    logic            b_v_reg;
    rrc_pkg::kind_t  b_kind_reg;
    logic [TW-1:0]   b_ts_reg;
    // Stage C: scaled span.
    logic            c_v_reg;
    rrc_pkg::kind_t  c_kind_reg;
    logic signed [P_W-1:0] c_prod_reg;
    // Output register.
    logic            out_valid_reg;
    logic signed [W-1:0] mapped_reg;

    logic [IW:0]     idx;
    logic [IW:0]     lo_idx;
    logic [TW-1:0]   lo_val;
    logic [TW-1:0]   hi_val;
    logic [TW-1:0]   lo_next;
    logic [TW-1:0]   diff_next;
    logic [TW+F-1:0] interp;
    logic [TW-1:0]   ts_next;
    logic signed [W:0] span;
    logic signed [W:0] mid_sum;
    logic signed [P_W-1:0] prod_next;
    logic signed [P_W-1:0] scaled;
    logic signed [W-1:0] mapped_next;

    assign advance   = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign mapped    = mapped_reg;

    // Table lookup: the top bits of t pick the segment, the rest interpolate.
    always_comb
    begin
        idx    = in_item.t[F:F-IW];
        lo_idx = {1'b0, idx[IW-1:0]};
        lo_val = rrc_pkg::LOG_ROM[lo_idx];
        hi_val = rrc_pkg::LOG_ROM[lo_idx + 1'b1];
        if (idx[IW])
        begin
            lo_next   = rrc_pkg::LOG_ROM[rrc_pkg::LOG_TABLE_ENTRIES];
            diff_next = '0;
        end
        else
        begin
            lo_next   = lo_val;
            diff_next = (hi_val < lo_val) ? '0 : (hi_val - lo_val);
        end
    end

    always_comb
    begin
        interp = a_diff_reg * a_frac_reg;
        case (cfg.curve)
            rrc_pkg::CURVE_SQRT: ts_next = a_root_reg;
            rrc_pkg::CURVE_LOG:  ts_next = a_lo_reg + interp[TW+F-1:F];
            default:             ts_next = a_t_reg;
        endcase
    end

    always_comb
    begin
        span      = $signed({cfg.out_high[W-1], cfg.out_high})
                  - $signed({cfg.out_low[W-1], cfg.out_low});
        prod_next = P_W'($signed({1'b0, b_ts_reg}) * span);
        // Arithmetic shift floors toward minus infinity for either direction.
        scaled    = c_prod_reg >>> F;
        mid_sum   = $signed({cfg.out_low[W-1], cfg.out_low})
                  + $signed({cfg.out_high[W-1], cfg.out_high});
        case (c_kind_reg)
            rrc_pkg::KIND_NAN: mapped_next = cfg.out_low;
            rrc_pkg::KIND_MID: mapped_next = mid_sum[W:1];
            default:           mapped_next = cfg.out_low + scaled[W-1:0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg       <= 1'b0;
            b_v_reg       <= 1'b0;
            c_v_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_v_reg       <= in_valid;
            b_v_reg       <= a_v_reg;
            c_v_reg       <= b_v_reg;
            out_valid_reg <= c_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_kind_reg <= in_item.kind;
            a_t_reg    <= in_item.t;
            a_root_reg <= in_root;
            a_lo_reg   <= lo_next;
            a_diff_reg <= diff_next;
            a_frac_reg <= {in_item.t[F-IW-1:0], {IW{1'b0}}};
            b_kind_reg <= a_kind_reg;
            b_ts_reg   <= ts_next;
            c_kind_reg <= b_kind_reg;
            c_prod_reg <= prod_next;
            mapped_reg <= mapped_next;
        end
    end

endmodule

[design/range_remap_with_curve.sv]
// ----------------------------------------------------------------------------
// range_remap_with_curve: linear range remap with a shaping curve
// Normalizes a Q16.16 sample against a configured input range, shapes the
// clamped ratio by a linear, square-root or log curve and maps it into the
// configured output range.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake             Beat contents
//  -------   ---------  --------------------  ------------------------------
//  input     in         in_valid / in_stall   sample, sample_finite
//  output    out        out_valid / out_stall mapped
//  config    in         cfg_write             cfg_index, cfg_data
//
// One beat is accepted per clock and one result leaves per clock at steady
// state while the output is not stalled. With the queue empty a beat passes
// the front register, which loads at the accepting edge, then one queue slot,
// seventeen divider stages (a load stage and sixteen quotient-bit stages),
// seventeen square-root stages, table read, curve select, span multiply and
// the output register; the divider and square-root pipelines form most of it.
// Reset clears all valid state and loads the register defaults; there is no
// clearing pass. A stalled output beat freezes the whole back pipeline; the
// four-entry queue keeps taking input until it fills, then in_stall rises.
//
module range_remap_with_curve (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [rrc_pkg::Q_W-1:0]        sample,
    input  logic                                  sample_finite,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [rrc_pkg::Q_W-1:0]        mapped,
    input  logic                                  cfg_write,
    input  logic [rrc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [rrc_pkg::Q_W-1:0]               cfg_data
);

    rrc_pkg::cfg_t  cfg_reg;
    rrc_pkg::job_t  front_job;
    logic           front_valid;
    logic           fifo_full;
    logic           fifo_empty;
    rrc_pkg::job_t  fifo_head;
    logic           advance;
    logic           fifo_pop;
    logic           div_valid;
    rrc_pkg::tval_t div_item;
    logic           sqrt_valid;
    rrc_pkg::tval_t sqrt_item;
    logic [rrc_pkg::T_W-1:0] sqrt_root;

    // Configuration registers; an index past the last register is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.in_low   <= 32'sd0;
            cfg_reg.in_high  <= 32'sd65536;
            cfg_reg.out_low  <= 32'sd131072;
            cfg_reg.out_high <= 32'sd786432;
            cfg_reg.curve    <= rrc_pkg::CURVE_LIN;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                rrc_pkg::REG_IN_LOW:       cfg_reg.in_low   <= cfg_data;
                rrc_pkg::REG_IN_HIGH:      cfg_reg.in_high  <= cfg_data;
                rrc_pkg::REG_OUT_LOW:      cfg_reg.out_low  <= cfg_data;
                rrc_pkg::REG_OUT_HIGH:     cfg_reg.out_high <= cfg_data;
                rrc_pkg::REG_CURVE_SELECT: cfg_reg.curve    <= cfg_data[1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Front part: classify and hand the job to the queue.
    rrc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample        (sample),
        .sample_finite (sample_finite),
        .cfg           (cfg_reg),
        .job_valid     (front_valid),
        .job           (front_job),
        .job_full      (fifo_full)
    );

    rrc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_valid),
        .push_data (front_job),
        .full      (fifo_full),
        .pop       (fifo_pop),
        .pop_data  (fifo_head),
        .empty     (fifo_empty)
    );

    // Back part: every stage moves together unless the output beat waits.
    assign fifo_pop = advance && !fifo_empty;

    rrc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (!fifo_empty),
        .in_job    (fifo_head),
        .out_valid (div_valid),
        .out_item  (div_item)
    );

    rrc_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (div_valid),
        .in_item   (div_item),
        .out_valid (sqrt_valid),
        .out_item  (sqrt_item),
        .root      (sqrt_root)
    );

    rrc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (sqrt_valid),
        .in_item   (sqrt_item),
        .in_root   (sqrt_root),
        .advance   (advance),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .mapped    (mapped)
    );

    // The input only stalls when the front holds a job that the full queue
    // cannot take.
    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (front_valid && fifo_full))
        else $error("input stalled without a full queue");

    // The back pipeline only freezes behind a waiting output beat.
    a_freeze_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |-> out_valid)
        else $error("back pipeline frozen with no output beat");

    // A stalled output beat stays presented and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(mapped)))
        else $error("stalled output beat changed");

endmodule
